// ===== rtl/bsls_pkg.sv =====
// Shared types, character codes, token kinds and keyword tables for the lexical scanner.
package bsls_pkg;

  localparam int MAX_TOKEN_LEN_DEF = 255;
  localparam int RES_DEPTH         = 4;

  // open token class
  localparam logic [1:0] CLS_NONE    = 2'd0;
  localparam logic [1:0] CLS_NUMBER  = 2'd1;
  localparam logic [1:0] CLS_WORD    = 2'd2;
  localparam logic [1:0] CLS_COMMENT = 2'd3;

  localparam logic [3:0] ALL_WORDS = 4'hf;

  typedef logic [4:0] kind_t;

  localparam kind_t KIND_LPAREN   = 5'd0;
  localparam kind_t KIND_RPAREN   = 5'd1;
  localparam kind_t KIND_LBRACKET = 5'd2;
  localparam kind_t KIND_RBRACKET = 5'd3;
  localparam kind_t KIND_LBRACE   = 5'd4;
  localparam kind_t KIND_RBRACE   = 5'd5;
  localparam kind_t KIND_SEMI     = 5'd6;
  localparam kind_t KIND_COMMA    = 5'd7;
  localparam kind_t KIND_PLUS     = 5'd8;
  localparam kind_t KIND_INC      = 5'd9;
  localparam kind_t KIND_MINUS    = 5'd10;
  localparam kind_t KIND_DEC      = 5'd11;
  localparam kind_t KIND_MUL      = 5'd12;
  localparam kind_t KIND_DIV      = 5'd13;
  localparam kind_t KIND_MOD      = 5'd14;
  localparam kind_t KIND_GT       = 5'd15;
  localparam kind_t KIND_GE       = 5'd16;
  localparam kind_t KIND_LT       = 5'd17;
  localparam kind_t KIND_LE       = 5'd18;
  localparam kind_t KIND_EQEQ     = 5'd19;
  localparam kind_t KIND_ASSIGN   = 5'd20;
  localparam kind_t KIND_COMMENT  = 5'd21;
  localparam kind_t KIND_INT      = 5'd22;
  localparam kind_t KIND_FLOAT    = 5'd23;
  localparam kind_t KIND_KW_BASE  = 5'd24;
  localparam kind_t KIND_IDENT    = 5'd28;
  localparam kind_t KIND_UNKNOWN  = 5'd29;

  localparam logic [7:0] CH_NUL      = 8'h00;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_NL       = 8'h0a;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_PERCENT  = 8'h25;
  localparam logic [7:0] CH_LPAREN   = 8'h28;
  localparam logic [7:0] CH_RPAREN   = 8'h29;
  localparam logic [7:0] CH_STAR     = 8'h2a;
  localparam logic [7:0] CH_PLUS     = 8'h2b;
  localparam logic [7:0] CH_COMMA    = 8'h2c;
  localparam logic [7:0] CH_MINUS    = 8'h2d;
  localparam logic [7:0] CH_DOT      = 8'h2e;
  localparam logic [7:0] CH_SLASH    = 8'h2f;
  localparam logic [7:0] CH_SEMI     = 8'h3b;
  localparam logic [7:0] CH_LT       = 8'h3c;
  localparam logic [7:0] CH_EQ       = 8'h3d;
  localparam logic [7:0] CH_GT       = 8'h3e;
  localparam logic [7:0] CH_LBRACKET = 8'h5b;
  localparam logic [7:0] CH_RBRACKET = 8'h5d;
  localparam logic [7:0] CH_LBRACE   = 8'h7b;
  localparam logic [7:0] CH_RBRACE   = 8'h7d;

  // Alphabet, AND, case, Collection
  localparam int KW_LEN [4] = '{8, 3, 4, 10};
  localparam logic [7:0] KW_CHAR [4][10] = '{
    '{8'h41, 8'h6c, 8'h70, 8'h68, 8'h61, 8'h62, 8'h65, 8'h74, 8'h00, 8'h00},
    '{8'h41, 8'h4e, 8'h44, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h63, 8'h61, 8'h73, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h43, 8'h6f, 8'h6c, 8'h6c, 8'h65, 8'h63, 8'h74, 8'h69, 8'h6f, 8'h6e}
  };

  typedef struct packed {
    kind_t      kind;
    logic [7:0] length;
    logic       last;
  } res_item_t;

  // up to two results from one byte, item0 first
  typedef struct packed {
    logic [1:0] cnt;
    res_item_t  item1;
    res_item_t  item0;
  } res_set_t;

  function automatic res_set_t push_res(res_set_t r, kind_t k, logic [7:0] l);
    res_set_t o;
    o = r;
    if (r.cnt == 2'd0) begin
      o.item0 = '{kind: k, length: l, last: 1'b0};
      o.cnt   = 2'd1;
    end else if (r.cnt == 2'd1) begin
      o.item1 = '{kind: k, length: l, last: 1'b0};
      o.cnt   = 2'd2;
    end
    return o;
  endfunction

  function automatic kind_t single_kind(logic [7:0] op);
    kind_t k;
    case (op)
      CH_PLUS:  k = KIND_PLUS;
      CH_MINUS: k = KIND_MINUS;
      CH_SLASH: k = KIND_DIV;
      CH_GT:    k = KIND_GT;
      CH_LT:    k = KIND_LT;
      CH_EQ:    k = KIND_ASSIGN;
      default:  k = KIND_UNKNOWN;
    endcase
    return k;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_letter(logic [7:0] c);
    return c inside {[8'h41:8'h5a], [8'h61:8'h7a]};
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return c inside {CH_SPACE, CH_TAB, CH_NL, CH_NUL};
  endfunction

  // keyword k still matches with character c at position pos
  function automatic logic kw_match(int k, int pos, logic [7:0] c);
    logic [3:0] p;
    p = pos[3:0];
    if (pos >= KW_LEN[k]) return 1'b0;
    return KW_CHAR[k][p] == c;
  endfunction

endpackage

// ===== rtl/bsls_if.sv =====
// Valid/ready channel interfaces for source bytes and token results.
interface bsls_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, text_byte, end_of_text, input ready);
  modport sink (input valid, text_byte, end_of_text, output ready);
endinterface

interface bsls_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] token_kind;
  logic [7:0] token_length;
  logic       last_of_run;

  modport source (output valid, token_kind, token_length, last_of_run, input ready);
  modport sink (input valid, token_kind, token_length, last_of_run, output ready);
endinterface

// ===== rtl/bsls_scan.sv =====
// Byte input register and scanner state with its single-pass next-state logic.
module bsls_scan #(
  parameter int MAX_TOKEN_LEN = bsls_pkg::MAX_TOKEN_LEN_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  bsls_in_if.sink             in_ch,
  input  logic                room,
  output bsls_pkg::res_set_t  res
);

  localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 1);

  typedef logic [LEN_W-1:0] len_t;

  typedef struct packed {
    logic [1:0] cls;
    len_t       len;
    logic       per;
    logic [3:0] cand;
    logic [7:0] pend;
  } scan_st_t;

  typedef struct packed {
    scan_st_t           st;
    bsls_pkg::res_set_t res;
  } step_t;

  localparam scan_st_t ST_RESET = '{
    cls: bsls_pkg::CLS_NONE, len: '0, per: 1'b0, cand: bsls_pkg::ALL_WORDS, pend: 8'h00
  };

  logic       in_vld_r;
  logic [7:0] byte_r;
  logic       end_r;
  scan_st_t   st_r;
  scan_st_t   st_nxt;
  step_t      step;
  logic       go;

  function automatic logic [7:0] sat8(len_t l);
    if (32'(l) > 32'd255) return 8'hff;
    return 8'(l);
  endfunction

  function automatic step_t emit(step_t t, bsls_pkg::kind_t k, logic [7:0] l);
    step_t o;
    o = t;
    o.res = bsls_pkg::push_res(t.res, k, l);
    return o;
  endfunction

  function automatic step_t bump(step_t t);
    step_t o;
    o = t;
    if (32'(t.st.len) < MAX_TOKEN_LEN) o.st.len = t.st.len + len_t'(1);
    return o;
  endfunction

  function automatic step_t track(step_t t, logic [7:0] c, int pos);
    step_t o;
    o = t;
    for (int k = 0; k < 4; k++) begin
      if (!bsls_pkg::kw_match(k, pos, c)) o.st.cand[k] = 1'b0;
    end
    return o;
  endfunction

  function automatic step_t close_open(step_t t);
    step_t           o;
    bsls_pkg::kind_t k;
    o = t;
    k = bsls_pkg::KIND_IDENT;
    case (t.st.cls)
      bsls_pkg::CLS_NUMBER: begin
        o = emit(o, t.st.per ? bsls_pkg::KIND_FLOAT : bsls_pkg::KIND_INT, sat8(t.st.len));
      end
      bsls_pkg::CLS_WORD: begin
        for (int i = 0; i < 4; i++) begin
          if (t.st.cand[i] && 32'(t.st.len) == bsls_pkg::KW_LEN[i])
            k = bsls_pkg::KIND_KW_BASE + 5'(i);
        end
        o = emit(o, k, sat8(t.st.len));
      end
      bsls_pkg::CLS_COMMENT: begin
        o = emit(o, bsls_pkg::KIND_COMMENT, sat8(t.st.len));
      end
      default: ;
    endcase
    o.st.cls  = bsls_pkg::CLS_NONE;
    o.st.len  = '0;
    o.st.per  = 1'b0;
    o.st.cand = bsls_pkg::ALL_WORDS;
    return o;
  endfunction

  function automatic step_t fresh(step_t t, logic [7:0] c);
    step_t o;
    o = t;
    case (c)
      bsls_pkg::CH_LPAREN:   o = emit(o, bsls_pkg::KIND_LPAREN, 8'd1);
      bsls_pkg::CH_RPAREN:   o = emit(o, bsls_pkg::KIND_RPAREN, 8'd1);
      bsls_pkg::CH_LBRACKET: o = emit(o, bsls_pkg::KIND_LBRACKET, 8'd1);
      bsls_pkg::CH_RBRACKET: o = emit(o, bsls_pkg::KIND_RBRACKET, 8'd1);
      bsls_pkg::CH_LBRACE:   o = emit(o, bsls_pkg::KIND_LBRACE, 8'd1);
      bsls_pkg::CH_RBRACE:   o = emit(o, bsls_pkg::KIND_RBRACE, 8'd1);
      bsls_pkg::CH_SEMI:     o = emit(o, bsls_pkg::KIND_SEMI, 8'd1);
      bsls_pkg::CH_COMMA:    o = emit(o, bsls_pkg::KIND_COMMA, 8'd1);
      bsls_pkg::CH_STAR:     o = emit(o, bsls_pkg::KIND_MUL, 8'd1);
      bsls_pkg::CH_PERCENT:  o = emit(o, bsls_pkg::KIND_MOD, 8'd1);
      bsls_pkg::CH_PLUS, bsls_pkg::CH_MINUS, bsls_pkg::CH_SLASH, bsls_pkg::CH_GT,
      bsls_pkg::CH_LT, bsls_pkg::CH_EQ, bsls_pkg::CH_DOT: begin
        o.st.pend = c;
      end
      default: begin
        if (bsls_pkg::is_space(c)) begin
          o = t;
        end else if (bsls_pkg::is_digit(c)) begin
          o.st.cls = bsls_pkg::CLS_NUMBER;
          o.st.len = len_t'(1);
          o.st.per = 1'b0;
        end else if (bsls_pkg::is_letter(c)) begin
          o.st.cls  = bsls_pkg::CLS_WORD;
          o.st.len  = len_t'(1);
          o.st.cand = bsls_pkg::ALL_WORDS;
          o = track(o, c, 0);
        end else begin
          o = emit(o, bsls_pkg::KIND_UNKNOWN, 8'd1);
        end
      end
    endcase
    return o;
  endfunction

  function automatic step_t resolve(step_t t, logic [7:0] c);
    step_t      o;
    logic [7:0] op;
    o  = t;
    op = t.st.pend;
    o.st.pend = 8'h00;
    if (op == bsls_pkg::CH_PLUS && c == bsls_pkg::CH_PLUS) begin
      o = emit(o, bsls_pkg::KIND_INC, 8'd2);
    end else if (op == bsls_pkg::CH_MINUS && c == bsls_pkg::CH_MINUS) begin
      o = emit(o, bsls_pkg::KIND_DEC, 8'd2);
    end else if (op == bsls_pkg::CH_GT && c == bsls_pkg::CH_EQ) begin
      o = emit(o, bsls_pkg::KIND_GE, 8'd2);
    end else if (op == bsls_pkg::CH_LT && c == bsls_pkg::CH_EQ) begin
      o = emit(o, bsls_pkg::KIND_LE, 8'd2);
    end else if (op == bsls_pkg::CH_EQ && c == bsls_pkg::CH_EQ) begin
      o = emit(o, bsls_pkg::KIND_EQEQ, 8'd2);
    end else if (op == bsls_pkg::CH_SLASH && c == bsls_pkg::CH_SLASH) begin
      o.st.cls = bsls_pkg::CLS_COMMENT;
      o.st.len = len_t'(2);
    end else if (op == bsls_pkg::CH_DOT && bsls_pkg::is_digit(c)) begin
      o.st.cls = bsls_pkg::CLS_NUMBER;
      o.st.len = len_t'(2);
      o.st.per = 1'b1;
    end else begin
      o = emit(o, bsls_pkg::single_kind(op), 8'd1);
      o = fresh(o, c);
    end
    return o;
  endfunction

  assign go          = in_vld_r && room;
  assign in_ch.ready = !in_vld_r || room;

  always_comb begin
    step.st  = st_r;
    step.res = '0;
    case (st_r.cls)
      bsls_pkg::CLS_COMMENT: begin
        if (byte_r == bsls_pkg::CH_NL || byte_r == bsls_pkg::CH_NUL) step = close_open(step);
        else step = bump(step);
      end
      bsls_pkg::CLS_NUMBER: begin
        if (bsls_pkg::is_digit(byte_r)) begin
          step = bump(step);
        end else if (byte_r == bsls_pkg::CH_DOT && !st_r.per) begin
          step.st.per = 1'b1;
          step = bump(step);
        end else begin
          step = close_open(step);
          step = fresh(step, byte_r);
        end
      end
      bsls_pkg::CLS_WORD: begin
        if (bsls_pkg::is_letter(byte_r) || bsls_pkg::is_digit(byte_r)) begin
          step = track(step, byte_r, 32'(st_r.len));
          step = bump(step);
        end else begin
          step = close_open(step);
          step = fresh(step, byte_r);
        end
      end
      default: begin
        if (st_r.pend != 8'h00) step = resolve(step, byte_r);
        else step = fresh(step, byte_r);
      end
    endcase

    // end flag flushes whatever is open or pending
    if (end_r) begin
      if (step.st.cls != bsls_pkg::CLS_NONE) step = close_open(step);
      if (step.st.pend != 8'h00)
        step = emit(step, bsls_pkg::single_kind(step.st.pend), 8'd1);
      step.st = ST_RESET;
    end

    if (step.res.cnt == 2'd1) step.res.item0.last = 1'b1;
    else if (step.res.cnt == 2'd2) step.res.item1.last = 1'b1;
  end

  assign st_nxt = step.st;

  always_comb begin
    res = step.res;
    if (!go) res.cnt = 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      st_r     <= ST_RESET;
    end else begin
      if (in_ch.ready) in_vld_r <= in_ch.valid;
      if (go) st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      byte_r <= in_ch.text_byte;
      end_r  <= in_ch.end_of_text;
    end
  end

  // an end beat leaves the scanner in its reset state
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    go && end_r |=> st_r.cls == bsls_pkg::CLS_NONE && st_r.pend == 8'h00 && st_r.len == '0)
    else $error("scanner state not cleared after end beat");

  // an open token and a pending operator never coexist
  a_open_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.cls != bsls_pkg::CLS_NONE |-> st_r.pend == 8'h00)
    else $error("pending operator while a token is open");

  a_idle_len: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.cls == bsls_pkg::CLS_NONE |-> st_r.len == '0 && !st_r.per)
    else $error("stale length or period with no open token");

endmodule

// ===== rtl/bsls_fifo.sv =====
// Result queue: takes up to two tokens a cycle, hands out one per beat.
module bsls_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  bsls_pkg::res_set_t push,
  output logic               room,
  bsls_out_if.source         out_ch
);

  localparam int PTR_W = $clog2(bsls_pkg::RES_DEPTH);

  bsls_pkg::res_item_t mem_r [bsls_pkg::RES_DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r;
  logic [PTR_W-1:0]    rd_ptr_r;
  logic [PTR_W:0]      count_r;
  logic [PTR_W:0]      count_nxt;
  logic                pop;

  assign pop       = out_ch.valid && out_ch.ready;
  assign room      = count_r <= (PTR_W+1)'(bsls_pkg::RES_DEPTH - 2);
  assign count_nxt = count_r + (PTR_W+1)'(push.cnt) - (PTR_W+1)'(pop);

  assign out_ch.valid        = count_r != '0;
  assign out_ch.token_kind   = mem_r[rd_ptr_r].kind;
  assign out_ch.token_length = mem_r[rd_ptr_r].length;
  assign out_ch.last_of_run  = mem_r[rd_ptr_r].last;

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) mem_r[wr_ptr_r] <= push.item0;
    if (push.cnt == 2'd2) mem_r[wr_ptr_r + PTR_W'(1)] <= push.item1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + PTR_W'(push.cnt);
      if (pop) rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      count_r <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (PTR_W+1)'(bsls_pkg::RES_DEPTH))
    else $error("result queue overflow");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    push.cnt == 2'd2 |-> !push.item0.last && push.item1.last)
    else $error("last_of_run not on final token of a byte");

endmodule

// ===== rtl/byte_stream_lexical_scanner.sv =====
// A token is offered on out_ch after the byte beat that completes it passes the input
// register, then the result queue, and waits longer while the queue has no room.
// Throughput: one byte per cycle while the four-entry result queue holds two or fewer
// tokens; out_ch drains one token per cycle while ready, so two-token bytes set the pace.
// Reset (rst_n low, synchronous): no token open, nothing pending, keyword candidates
// all set, result queue empty.
// Top level of the byte stream lexical scanner.
module byte_stream_lexical_scanner #(
  parameter int MAX_TOKEN_LEN = bsls_pkg::MAX_TOKEN_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  bsls_in_if.sink     in_ch,
  bsls_out_if.source  out_ch
);

  bsls_pkg::res_set_t res;
  logic               room;

  bsls_scan #(
    .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
  ) u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .room  (room),
    .res   (res)
  );

  bsls_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (res),
    .room   (room),
    .out_ch (out_ch)
  );

endmodule
